FILE: hdl/wavenumber_palette_index_map_macros.svh
// ----------------------------------------------------------------------------
// Wavenumber palette index map: assertion macros
// Clocked assertions on i_clk, held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WAVENUMBER_PALETTE_INDEX_MAP_MACROS_SVH
`define WAVENUMBER_PALETTE_INDEX_MAP_MACROS_SVH

// assert a property on every clock edge outside reset
`define WPIM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// assert that a condition is followed by another in the next cycle
`define WPIM_ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (nxt)) else $error(msg);

`endif

FILE: hdl/wpim_pkg.sv
// ----------------------------------------------------------------------------
// Wavenumber palette index map: package
// Word types, opcodes, status codes and fixed field widths.
// ----------------------------------------------------------------------------
package wpim_pkg;

    localparam int COORD_W       = 5;
    localparam int COORD_LOG_MAX = 5;
    localparam int MAG_W         = 10;
    localparam int LOG_W         = 3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] ST_NEW     = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISS    = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_in_word;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude_sq;
        logic [7:0]       palette_index;
        logic [8:0]       entry_total;
        logic [1:0]       status;
    } t_out_word;

endpackage

FILE: hdl/wavenumber_palette_index_map.sv
// ----------------------------------------------------------------------------
// Wavenumber palette index map
// Builds a sorted table of distinct squared wavenumber magnitudes and
// answers palette index lookups for bit-reversed map positions.
// ----------------------------------------------------------------------------
// Command word on i_word is taken at a clock edge with start high and busy
// low; busy stays high until the result word is out. Opcode insert adds the
// bin magnitude to the table if new, opcode lookup returns the index of the
// bit-reversed bin. Each command gives one result word on o_word, marked by
// o_valid for a single cycle; the receiver cannot stall it.
// Sequence: the magnitude is formed in state S_CALC, then the table is
// scanned upwards one entry a cycle through its single read port until an
// entry not below the magnitude turns up (position i, at most entry_total).
// A new insert then moves the entries from i upwards up one place, again
// one a cycle, and writes the magnitude.
// Config word on i_cfg_wdata sets width_log2; the user must write it only
// while idle, as the block itself does not enforce this.
// Reset empties the table (count to zero, no clearing pass) and sets
// width_log2 to 5.
// ----------------------------------------------------------------------------
`include "wavenumber_palette_index_map_macros.svh"

module wavenumber_palette_index_map #(
    parameter int MAX_WIDTH   = 32,
    parameter int TABLE_DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  wpim_pkg::t_in_word               i_word,
    output logic                             o_valid,
    output wpim_pkg::t_out_word              o_word,
    input  logic                             i_cfg_we,
    input  logic [wpim_pkg::LOG_W-1:0]       i_cfg_wdata
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CNW = $clog2(TABLE_DEPTH + 1);
    localparam int MW  = wpim_pkg::MAG_W;
    localparam int LOG_FLOOR = $clog2(MAX_WIDTH + 1) - 1;
    localparam logic [wpim_pkg::LOG_W-1:0] LOG_LIM =
        wpim_pkg::LOG_W'((LOG_FLOOR < wpim_pkg::COORD_LOG_MAX) ?
                         LOG_FLOOR : wpim_pkg::COORD_LOG_MAX);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CALC  = 2'd1;
    localparam logic [1:0] S_SRCH  = 2'd2;
    localparam logic [1:0] S_SHIFT = 2'd3;

    logic [1:0]                   r_state, n_state;
    wpim_pkg::t_in_word           r_word, n_word;
    logic [MW-1:0]                r_sq, n_sq;
    logic [CNW-1:0]               r_addr, n_addr;
    logic [CNW-1:0]               r_chk, n_chk;
    logic [CNW-1:0]               r_pos, n_pos;
    logic [CNW-1:0]               r_count, n_count;
    logic                         r_pend, n_pend;
    logic                         r_more, n_more;
    logic                         r_valid, n_valid;
    wpim_pkg::t_out_word          r_res, n_res;
    logic [wpim_pkg::LOG_W-1:0]   r_width;

    logic [wpim_pkg::LOG_W-1:0]   eff_lg;
    logic [MW-1:0]                mag_sq;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [MW-1:0]                rd_data;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [MW-1:0]                wr_data;
    logic                         hit;
    logic                         equal;
    logic [CNW-1:0]               pos_f;
    logic [CNW-1:0]               chk_up;

    always_comb begin
        if (r_width == '0) begin
            eff_lg = wpim_pkg::LOG_W'(1);
        end else if (r_width > LOG_LIM) begin
            eff_lg = LOG_LIM;
        end else begin
            eff_lg = r_width;
        end
    end

    wpim_mag u_mag (
        .i_op  (r_word.opcode),
        .i_row (r_word.row),
        .i_col (r_word.col),
        .i_lg  (eff_lg),
        .o_sq  (mag_sq)
    );

    wpim_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .DW    (MW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state = r_state;
        n_word  = r_word;
        n_sq    = r_sq;
        n_addr  = r_addr;
        n_chk   = r_chk;
        n_pos   = r_pos;
        n_count = r_count;
        n_pend  = r_pend;
        n_more  = r_more;
        n_valid = 1'b0;
        n_res   = r_res;
        rd_en   = 1'b0;
        rd_addr = r_addr[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_pos[AW-1:0];
        wr_data = r_sq;
        hit     = r_pend && (rd_data >= r_sq);
        equal   = hit && (rd_data == r_sq);
        pos_f   = hit ? r_chk : r_count;
        chk_up  = r_chk + CNW'(1);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_word  = i_word;
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_sq    = mag_sq;
                n_addr  = '0;
                n_pend  = 1'b0;
                n_state = S_SRCH;
            end
            S_SRCH: begin
                if (hit || !(r_addr < r_count)) begin
                    n_res.magnitude_sq  = r_sq;
                    n_res.entry_total   = 9'(r_count);
                    n_res.palette_index = '0;
                    n_pend              = 1'b0;
                    if (equal) begin
                        n_res.status        = wpim_pkg::ST_PRESENT;
                        n_res.palette_index = 8'(pos_f);
                        n_valid             = 1'b1;
                        n_state             = S_IDLE;
                    end else if (r_word.opcode == wpim_pkg::OP_LOOKUP) begin
                        n_res.status = wpim_pkg::ST_MISS;
                        n_valid      = 1'b1;
                        n_state      = S_IDLE;
                    end else if (r_count == CNW'(TABLE_DEPTH)) begin
                        n_res.status = wpim_pkg::ST_FULL;
                        n_valid      = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_pos   = pos_f;
                        n_more  = (r_count != pos_f);
                        n_addr  = r_count - CNW'(1);
                        n_state = S_SHIFT;
                    end
                end else begin
                    rd_en  = 1'b1;
                    n_chk  = r_addr;
                    n_addr = r_addr + CNW'(1);
                    n_pend = 1'b1;
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = chk_up[AW-1:0];
                    wr_data = rd_data;
                end
                if (r_more) begin
                    rd_en  = 1'b1;
                    n_chk  = r_addr;
                    n_pend = 1'b1;
                    if (r_addr == r_pos) begin
                        n_more = 1'b0;
                    end else begin
                        n_addr = r_addr - CNW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        wr_en               = 1'b1;
                        n_count             = r_count + CNW'(1);
                        n_res.magnitude_sq  = r_sq;
                        n_res.palette_index = 8'(r_pos);
                        n_res.entry_total   = 9'(r_count + CNW'(1));
                        n_res.status        = wpim_pkg::ST_NEW;
                        n_valid             = 1'b1;
                        n_state             = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_more  <= 1'b0;
            r_valid <= 1'b0;
            r_width <= wpim_pkg::LOG_W'(wpim_pkg::COORD_LOG_MAX);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_more  <= n_more;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_width <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_sq   <= n_sq;
        r_addr <= n_addr;
        r_chk  <= n_chk;
        r_pos  <= n_pos;
        r_res  <= n_res;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_word  = r_res;

    `WPIM_ASSERT(a_valid_when_idle, !o_valid || !busy, "result word while busy")
    `WPIM_ASSERT(a_count_bound, r_count <= CNW'(TABLE_DEPTH), "entry count beyond depth")
    `WPIM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `WPIM_ASSERT(a_count_on_new, (r_count == $past(r_count)) || (o_valid && o_word.status == wpim_pkg::ST_NEW), "count moved without new insert")

endmodule

FILE: hdl/wpim_mag.sv
// ----------------------------------------------------------------------------
// Wavenumber palette index map: magnitude unit
// Masks a grid bin, bit-reverses it for lookups and forms kx^2 + kz^2.
// ----------------------------------------------------------------------------
module wpim_mag (
    input  logic                             i_op,
    input  logic [wpim_pkg::COORD_W-1:0]     i_row,
    input  logic [wpim_pkg::COORD_W-1:0]     i_col,
    input  logic [wpim_pkg::LOG_W-1:0]       i_lg,
    output logic [wpim_pkg::MAG_W-1:0]       o_sq
);

    localparam int CW = wpim_pkg::COORD_W;

    logic [CW:0]   w;
    logic [CW:0]   half;
    logic [CW-1:0] mask;
    logic [CW-1:0] shamt;

    function automatic logic [CW-1:0] rev_all(input logic [CW-1:0] v);
        logic [CW-1:0] r;
        for (int i = 0; i < CW; i++) begin
            r[i] = v[CW-1-i];
        end
        return r;
    endfunction

    function automatic logic [wpim_pkg::MAG_W-1:0] wave_sq(
        input logic [CW-1:0] v, input logic [CW:0] wv, input logic [CW:0] hv);
        logic [CW:0]     v6;
        logic [CW:0]     m;
        logic [2*CW+1:0] p;
        v6 = {1'b0, v};
        m  = (v6 < hv) ? v6 : (wv - v6);
        p  = m * m;
        return wpim_pkg::MAG_W'(p);
    endfunction

    logic [CW-1:0] row_m;
    logic [CW-1:0] col_m;
    logic [CW-1:0] row_e;
    logic [CW-1:0] col_e;

    always_comb begin
        w     = (CW+1)'(1) << i_lg;
        half  = w >> 1;
        mask  = CW'(w - (CW+1)'(1));
        shamt = CW'(wpim_pkg::COORD_LOG_MAX) - CW'(i_lg);
        row_m = i_row & mask;
        col_m = i_col & mask;
        if (i_op == wpim_pkg::OP_LOOKUP) begin
            row_e = rev_all(row_m) >> shamt;
            col_e = rev_all(col_m) >> shamt;
        end else begin
            row_e = row_m;
            col_e = col_m;
        end
        o_sq = wave_sq(row_e, w, half) + wave_sq(col_e, w, half);
    end

endmodule

FILE: hdl/wpim_ram.sv
// ----------------------------------------------------------------------------
// Wavenumber palette index map: table memory
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module wpim_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: test/wavenumber_palette_index_map_test.sv
// ----------------------------------------------------------------------------
// Wavenumber palette index map: testbench
// Drives insert and lookup command words across every grid width setting.
// A scoreboard class keeps its own sorted magnitude table, predicts each
// result word and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module wavenumber_palette_index_map_test;
    import wpim_pkg::*;

    localparam int          MAX_GRID    = 32;
    localparam int          TABLE_DEPTH = 256;
    localparam int          PHASE_WORDS = 195;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    class palette_ledger;
        logic [MAG_W-1:0] mags [TABLE_DEPTH];
        int unsigned      held;
        logic [LOG_W-1:0] width_reg;
        t_out_word        pending_words[$];
        int unsigned      fail_count;
        int unsigned      status_seen[4];
        int unsigned      words_checked;

        function new();
            held          = 0;
            width_reg     = LOG_W'(COORD_LOG_MAX);
            fail_count    = 0;
            words_checked = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function void set_width(logic [LOG_W-1:0] v);
            width_reg = v;
        endfunction

        function int unsigned grid_log2();
            int unsigned l;
            l = width_reg;
            if (l < 1) l = 1;
            if (l > COORD_LOG_MAX) l = COORD_LOG_MAX;
            while (l > 1 && (1 << l) > MAX_GRID) l--;
            return l;
        endfunction

        function int unsigned reverse_bits(int unsigned v, int unsigned bits);
            int unsigned r;
            r = 0;
            for (int unsigned k = 0; k < bits; k++) r = (r << 1) | ((v >> k) & 1);
            return r;
        endfunction

        function int unsigned wave_sq(int unsigned v, int unsigned grid);
            int unsigned m;
            m = (v < (grid >> 1)) ? v : grid - v;
            return m * m;
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function t_out_word predict_word(t_in_word w);
            t_out_word   res;
            int unsigned lg, grid, r, c, sq, pos, k;
            logic [1:0]  st;
            lg   = grid_log2();
            grid = 1 << lg;
            r    = w.row & (grid - 1);
            c    = w.col & (grid - 1);
            pos  = 0;
            if (w.opcode == OP_LOOKUP) begin
                r = reverse_bits(r, lg);
                c = reverse_bits(c, lg);
            end
            sq = wave_sq(r, grid) + wave_sq(c, grid);
            k = 0;
            while (k < held && mags[k] < sq) k++;
            if (k < held && mags[k] == sq) begin
                st  = ST_PRESENT;
                pos = k;
            end else if (w.opcode == OP_LOOKUP) begin
                st = ST_MISS;
            end else if (held >= TABLE_DEPTH) begin
                st = ST_FULL;
            end else begin
                for (int unsigned j = held; j > k; j--) mags[j] = mags[j-1];
                mags[k] = MAG_W'(sq);
                held++;
                st  = ST_NEW;
                pos = k;
            end
            res.magnitude_sq  = MAG_W'(sq);
            res.palette_index = 8'(pos);
            res.entry_total   = 9'(held);
            res.status        = st;
            return res;
        endfunction

        function void note_command(t_in_word w);
            t_out_word res;
            res = predict_word(w);
            status_seen[res.status]++;
            pending_words.push_back(res);
        endfunction

        task report(string what, int got, int want);
            if (fail_count < 30)
                $display("error: %s got %0d expected %0d at %0t", what, got, want, $realtime);
            fail_count++;
        endtask

        task check_word(t_out_word got);
            t_out_word want;
            if (pending_words.size() == 0) begin
                report("unexpected result word, magnitude", got.magnitude_sq, -1);
                return;
            end
            want = pending_words.pop_front();
            words_checked++;
            if (got.magnitude_sq !== want.magnitude_sq)
                report("magnitude_sq", got.magnitude_sq, want.magnitude_sq);
            if (got.palette_index !== want.palette_index)
                report("palette_index", got.palette_index, want.palette_index);
            if (got.entry_total !== want.entry_total)
                report("entry_total", got.entry_total, want.entry_total);
            if (got.status !== want.status)
                report("status", got.status, want.status);
        endtask

        task flush_leftovers();
            while (pending_words.size() != 0) begin
                report("missing result word, magnitude", -1,
                       pending_words[0].magnitude_sq);
                void'(pending_words.pop_front());
            end
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_in_word         i_word;
    logic             o_valid;
    t_out_word        o_word;
    logic             i_cfg_we;
    logic [LOG_W-1:0] i_cfg_wdata;

    palette_ledger ledger = new();
    int unsigned   cycles = 0;
    int unsigned   words_sent = 0;
    int unsigned   width_writes = 0;
    bit            steady = 0;

    wavenumber_palette_index_map #(
        .MAX_WIDTH   (MAX_GRID),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_word      (i_word),
        .o_valid     (o_valid),
        .o_word      (o_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) ledger.check_word(o_word);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_in_word make_word(logic op, int unsigned r, int unsigned c);
        t_in_word w;
        w.opcode = op;
        w.row    = COORD_W'(r);
        w.col    = COORD_W'(c);
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        @(negedge i_clk);
        start  <= 1'b1;
        i_word <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        ledger.note_command(w);
        words_sent++;
    endtask

    task automatic hold_off(input int unsigned n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (ledger.pending() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [LOG_W-1:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        ledger.set_width(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        width_writes++;
    endtask

    task automatic pace();
        if (!steady && $urandom_range(99) < 35) hold_off($urandom_range(1, 40));
        if ($urandom_range(99) < 1) drain();
    endtask

    // lookup position that maps back onto bin (r, c) at the current width
    function automatic t_in_word mirror_of(int unsigned r, int unsigned c);
        int unsigned lg, mask;
        lg   = ledger.grid_log2();
        mask = (1 << lg) - 1;
        return make_word(OP_LOOKUP,
            ledger.reverse_bits(r & mask, lg) | ($urandom_range(31) & ~mask),
            ledger.reverse_bits(c & mask, lg) | ($urandom_range(31) & ~mask));
    endfunction

    task automatic run_phase(input logic [LOG_W-1:0] width);
        int unsigned n, pick, r, c;
        write_width(width);
        n = 0;
        while (n < PHASE_WORDS) begin
            pick = $urandom_range(99);
            r    = $urandom_range(31);
            c    = $urandom_range(31);
            if (pick < 40) begin
                send_word(make_word(OP_INSERT, r, c));
                n++;
            end else if (pick < 75) begin
                send_word(make_word(OP_LOOKUP, r, c));
                n++;
            end else begin
                send_word(make_word(OP_INSERT, r, c));
                pace();
                send_word(mirror_of(r, c));
                n += 2;
            end
            pace();
        end
    endtask

    logic [LOG_W-1:0] phase_widths[10] = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd4,
                                           3'd6, 3'd5, 3'd7, 3'd2, 3'd5};

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_word      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_word(make_word(OP_LOOKUP, 0, 0));
        send_word(make_word(OP_LOOKUP, 31, 31));
        send_word(make_word(OP_INSERT, 0, 0));
        send_word(make_word(OP_INSERT, 0, 0));
        send_word(make_word(OP_LOOKUP, 0, 0));
        send_word(make_word(OP_INSERT, 31, 31));
        send_word(make_word(OP_INSERT, 16, 16));
        send_word(make_word(OP_INSERT, 16, 0));
        send_word(make_word(OP_INSERT, 0, 31));
        send_word(make_word(OP_LOOKUP, 31, 31));
        send_word(make_word(OP_LOOKUP, 1, 1));
        send_word(make_word(OP_LOOKUP, 2, 0));
        send_word(make_word(OP_INSERT, 5, 10));
        send_word(make_word(OP_LOOKUP, 20, 10));
        write_width(3'd0);
        send_word(make_word(OP_INSERT, 31, 31));
        send_word(make_word(OP_INSERT, 1, 0));
        send_word(make_word(OP_LOOKUP, 30, 31));
        write_width(3'd7);
        send_word(make_word(OP_INSERT, 17, 15));
        send_word(make_word(OP_LOOKUP, 17, 30));

        foreach (phase_widths[p]) begin
            steady = (p == 6);
            run_phase(phase_widths[p]);
        end
        steady = 0;

        drain();
        repeat (TABLE_DEPTH + 16) @(posedge i_clk);
        ledger.flush_leftovers();

        $display("Run covered %0d command words over %0d width writes, %0d palette entries.",
                 words_sent, width_writes, ledger.held);
        $display("Outcomes: %0d new, %0d present, %0d full, %0d missed lookups.",
                 ledger.status_seen[ST_NEW], ledger.status_seen[ST_PRESENT],
                 ledger.status_seen[ST_FULL], ledger.status_seen[ST_MISS]);
        if (ledger.fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
